// File: src/assert_macros.svh
// Assertion helpers for the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define DST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define DST_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/dst_pkg.sv
`default_nettype none

package dst_pkg;

	localparam int SLOTS_DEF = 8;

	localparam int OPCODE_W = 2;
	localparam int ADDR_W   = 7;
	localparam int INST_W   = 4;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 3;
	localparam int COUNT_W  = 4;

	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 16;
	localparam int M_TUSER_W = 2;

	localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

// File: src/device_slot_table_unit.sv
// Channel   Dir  tdata (low bit up)                                  tuser (low bit up)
// s_axis    in   dev_address[6:0], iface_instance[10:7], zero pad    opcode[1:0], match_any_instance[2]
// m_axis    out  slot_index[2:0], removed_count[6:3],                status[1:0]
//                entry_count[10:7], zero pad
//
// One operation at a time. Find and remove scan the slot memory one entry per cycle; add and
// the unused opcode do not scan. Remove closes gaps by writing each kept entry back during
// that same scan.
// Reset clears the entry count; slot contents are not cleared.
// The next input is taken while a result waits; a stalled result holds the block before its
// next result is loaded.
`default_nettype none

module device_slot_table_unit #(
	parameter int SLOTS = dst_pkg::SLOTS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [dst_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // dev_address, iface_instance
	input  wire logic [dst_pkg::S_TUSER_W-1:0]   s_axis_tuser,  // opcode, match_any_instance
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [dst_pkg::M_TDATA_W-1:0]        m_axis_tdata,  // slot_index, removed, entries
	output logic [dst_pkg::M_TUSER_W-1:0]        m_axis_tuser   // status
);

	dst_pkg::dp_cmd_t cmd;
	dst_pkg::dp_sts_t sts;

	logic [dst_pkg::INDEX_W-1:0] slot_index;
	logic [dst_pkg::COUNT_W-1:0] removed_count;
	logic [dst_pkg::COUNT_W-1:0] entry_count;

	dst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.sts      (sts),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	dst_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.opcode             (s_axis_tuser[1:0]),
		.dev_address        (s_axis_tdata[6:0]),
		.iface_instance     (s_axis_tdata[10:7]),
		.match_any_instance (s_axis_tuser[2]),
		.out_ready          (m_axis_tready),
		.out_valid          (m_axis_tvalid),
		.status             (m_axis_tuser),
		.slot_index         (slot_index),
		.removed_count      (removed_count),
		.entry_count        (entry_count),
		.sts                (sts)
	);

	assign m_axis_tdata = {5'b0, entry_count, removed_count, slot_index};

endmodule

`default_nettype wire

// File: src/dst_ctrl.sv
`default_nettype none

module dst_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire dst_pkg::dp_sts_t sts,
	output logic                  in_ready,
	output dst_pkg::dp_cmd_t      cmd
);

	dst_pkg::state_t state_q;
	dst_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dst_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dst_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nxt = dst_pkg::S_SCAN;
				end
			end
			dst_pkg::S_SCAN: begin
				if (sts.scan_done) begin
					state_nxt = dst_pkg::S_EMIT;
				end
			end
			dst_pkg::S_EMIT: begin
				if (sts.out_free) begin
					state_nxt = dst_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = dst_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			dst_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			dst_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
			end
			dst_pkg::S_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: src/dst_datapath.sv
`default_nettype none

`include "assert_macros.svh"

module dst_datapath #(
	parameter int SLOTS = dst_pkg::SLOTS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire dst_pkg::dp_cmd_t               cmd,
	input  wire logic [dst_pkg::OPCODE_W-1:0]   opcode,
	input  wire logic [dst_pkg::ADDR_W-1:0]     dev_address,
	input  wire logic [dst_pkg::INST_W-1:0]     iface_instance,
	input  wire logic                           match_any_instance,
	input  wire logic                           out_ready,
	output logic                                out_valid,
	output logic [dst_pkg::STATUS_W-1:0]        status,
	output logic [dst_pkg::INDEX_W-1:0]         slot_index,
	output logic [dst_pkg::COUNT_W-1:0]         removed_count,
	output logic [dst_pkg::COUNT_W-1:0]         entry_count,
	output dst_pkg::dp_sts_t                    sts
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	logic [dst_pkg::ADDR_W-1:0] addr_mem [SLOTS];
	logic [dst_pkg::INST_W-1:0] inst_mem [SLOTS];

	logic [dst_pkg::OPCODE_W-1:0] op_q;
	logic [dst_pkg::ADDR_W-1:0]   addr_q;
	logic [dst_pkg::INST_W-1:0]   inst_q;
	logic                         any_q;

	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] keep_q;
	logic [CW-1:0] removed_q;
	logic [CW-1:0] fill_q;
	logic          found_q;
	logic [IW-1:0] found_idx_q;
	logic          out_valid_q;

	logic                       vld_s1;
	logic [IW-1:0]              idx_s1;
	logic [dst_pkg::ADDR_W-1:0] addr_s1;
	logic [dst_pkg::INST_W-1:0] inst_s1;

	logic [dst_pkg::STATUS_W-1:0] status_q;
	logic [dst_pkg::INDEX_W-1:0]  slot_index_q;
	logic [dst_pkg::COUNT_W-1:0]  removed_count_q;
	logic [dst_pkg::COUNT_W-1:0]  entry_count_q;

	logic                         scan_op;
	logic                         rd_en;
	logic                         hit;
	logic                         full;
	logic                         keep_wr;
	logic                         add_wr;
	logic                         wr_en;
	logic [IW-1:0]                wr_idx;
	logic [dst_pkg::ADDR_W-1:0]   wr_addr;
	logic [dst_pkg::INST_W-1:0]   wr_inst;
	logic [dst_pkg::STATUS_W-1:0] res_status;
	logic [IW-1:0]                res_idx;
	logic [CW-1:0]                res_removed;
	logic [CW-1:0]                res_count;

	assign scan_op = (op_q == dst_pkg::OP_FIND) || (op_q == dst_pkg::OP_REMOVE);
	assign rd_en   = cmd.scan && scan_op && (rd_idx_q != fill_q);
	assign hit     = vld_s1 && (addr_s1 == addr_q) &&
	                 ((inst_s1 == inst_q) || ((op_q == dst_pkg::OP_REMOVE) && any_q));
	assign full    = (fill_q == CW'(SLOTS));
	assign keep_wr = vld_s1 && (op_q == dst_pkg::OP_REMOVE) && !hit;
	assign add_wr  = cmd.emit && (op_q == dst_pkg::OP_ADD) && !full;
	assign wr_en   = keep_wr || add_wr;
	assign wr_idx  = add_wr ? fill_q[IW-1:0] : keep_q[IW-1:0];
	assign wr_addr = add_wr ? addr_q : addr_s1;
	assign wr_inst = add_wr ? inst_q : inst_s1;

	assign sts.scan_done = !vld_s1 && (!scan_op || (rd_idx_q == fill_q));
	assign sts.out_free  = !out_valid_q || out_ready;

	always_comb begin
		res_status  = dst_pkg::ST_OK;
		res_idx     = '0;
		res_removed = '0;
		res_count   = fill_q;
		case (op_q)
			dst_pkg::OP_FIND: begin
				if (found_q) begin
					res_idx = found_idx_q;
				end else begin
					res_status = dst_pkg::ST_NOT_FOUND;
				end
			end
			dst_pkg::OP_ADD: begin
				if (full) begin
					res_status = dst_pkg::ST_FULL;
				end else begin
					res_idx   = fill_q[IW-1:0];
					res_count = CW'(fill_q + 1'b1);
				end
			end
			dst_pkg::OP_REMOVE: begin
				res_removed = removed_q;
				res_count   = keep_q;
			end
			default: begin
				res_status = dst_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			keep_q      <= '0;
			removed_q   <= '0;
			fill_q      <= '0;
			found_q     <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				rd_idx_q  <= '0;
				keep_q    <= '0;
				removed_q <= '0;
				found_q   <= 1'b0;
				vld_s1    <= 1'b0;
			end else begin
				vld_s1 <= rd_en;
				if (rd_en) begin
					rd_idx_q <= CW'(rd_idx_q + 1'b1);
				end
				if (vld_s1 && (op_q == dst_pkg::OP_REMOVE)) begin
					if (hit) begin
						removed_q <= CW'(removed_q + 1'b1);
					end else begin
						keep_q <= CW'(keep_q + 1'b1);
					end
				end
				if (hit && (op_q == dst_pkg::OP_FIND)) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				if (add_wr) begin
					fill_q <= CW'(fill_q + 1'b1);
				end else if (op_q == dst_pkg::OP_REMOVE) begin
					fill_q <= keep_q;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			addr_q <= dev_address;
			inst_q <= iface_instance;
			any_q  <= match_any_instance;
		end
		if (rd_en) begin
			addr_s1 <= addr_mem[rd_idx_q[IW-1:0]];
			inst_s1 <= inst_mem[rd_idx_q[IW-1:0]];
			idx_s1  <= rd_idx_q[IW-1:0];
		end
		if (wr_en) begin
			addr_mem[wr_idx] <= wr_addr;
			inst_mem[wr_idx] <= wr_inst;
		end
		if (hit && (op_q == dst_pkg::OP_FIND) && !found_q) begin
			found_idx_q <= idx_s1;
		end
		if (cmd.emit) begin
			status_q        <= res_status;
			slot_index_q    <= dst_pkg::INDEX_W'(res_idx);
			removed_count_q <= dst_pkg::COUNT_W'(res_removed);
			entry_count_q   <= dst_pkg::COUNT_W'(res_count);
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign slot_index    = slot_index_q;
	assign removed_count = removed_count_q;
	assign entry_count   = entry_count_q;

	`DST_ASSERT(a_fill_bound, fill_q <= CW'(SLOTS), "fill count exceeds table size")
	`DST_ASSERT(a_no_rw_clash, (wr_en && rd_en) |-> (wr_idx != rd_idx_q[IW-1:0]), "read clash")
	`DST_ASSERT(a_keep_behind, keep_q <= rd_idx_q, "compaction write ahead of scan")
	`DST_ASSERT(a_emit_idle_scan, cmd.emit |-> !vld_s1 && !rd_en, "emit during scan")

endmodule

`default_nettype wire

// File: tb/tb_device_slot_table_unit.sv
`default_nettype none

module tb_device_slot_table_unit;
	import dst_pkg::*;

	localparam int TABLE_SLOTS = SLOTS_DEF;
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD = 400;
	localparam int PHASE_ITEMS = 100;
	localparam int PHASES = 19;

	typedef struct {
		logic [OPCODE_W-1:0] opcode;
		logic [ADDR_W-1:0]   dev_address;
		logic [INST_W-1:0]   iface_instance;
		logic                match_any_instance;
		bit                  drain_first;
	} table_cmd_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  slot_index;
		logic [COUNT_W-1:0]  removed_count;
		logic [COUNT_W-1:0]  entry_count;
	} table_result_t;

	typedef enum {
		RX_FREE,
		RX_RANDOM,
		RX_SPARSE,
		RX_TOGGLE
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [S_TUSER_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [M_TUSER_W-1:0] m_axis_tuser;

	table_cmd_t pending_cmds[$];
	table_result_t expected_results[$];
	table_cmd_t in_flight;

	logic [ADDR_W-1:0] table_addr[TABLE_SLOTS];
	logic [INST_W-1:0] table_inst[TABLE_SLOTS];
	int table_fill = 0;

	int mismatch_count = 0;
	int items_accepted = 0;
	int burst_left = 1;
	int gap_left = 0;
	int idle_cycles = 0;
	int hold_left = 0;
	bit long_hold_done = 0;
	int mode_left = 0;
	rx_mode_t rx_mode = RX_FREE;

	logic [ADDR_W-1:0] addr_mask;
	logic [INST_W-1:0] inst_mask;

	device_slot_table_unit #(.SLOTS(TABLE_SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic table_result_t apply_table_op(table_cmd_t c);
		table_result_t r;
		int i;
		int keep;
		bit hit;
		r = '{default: '0};
		case (c.opcode)
			OP_FIND: begin
				r.status = ST_NOT_FOUND;
				for (i = 0; i < table_fill; i++) begin
					if (r.status == ST_NOT_FOUND && table_addr[i] == c.dev_address &&
							table_inst[i] == c.iface_instance) begin
						r.status = ST_OK;
						r.slot_index = i[INDEX_W-1:0];
					end
				end
			end
			OP_ADD: begin
				if (table_fill >= TABLE_SLOTS) begin
					r.status = ST_FULL;
				end else begin
					table_addr[table_fill] = c.dev_address;
					table_inst[table_fill] = c.iface_instance;
					r.slot_index = table_fill[INDEX_W-1:0];
					table_fill++;
				end
			end
			OP_REMOVE: begin
				keep = 0;
				for (i = 0; i < table_fill; i++) begin
					hit = table_addr[i] == c.dev_address &&
						(c.match_any_instance || table_inst[i] == c.iface_instance);
					if (hit) begin
						r.removed_count++;
					end else begin
						table_addr[keep] = table_addr[i];
						table_inst[keep] = table_inst[i];
						keep++;
					end
				end
				table_fill = keep;
			end
			default: ;
		endcase
		r.entry_count = table_fill[COUNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (mismatch_count < 40)
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic push_cmd(input logic [OPCODE_W-1:0] op, input logic [ADDR_W-1:0] addr,
			input logic [INST_W-1:0] inst, input logic any, input bit drain);
		table_cmd_t c;
		c.opcode = op;
		c.dev_address = addr;
		c.iface_instance = inst;
		c.match_any_instance = any;
		c.drain_first = drain;
		pending_cmds.push_back(c);
	endtask

	// mostly a small pool of addresses and instances so that matches are common
	function automatic logic [ADDR_W-1:0] pick_address();
		if ($urandom_range(0, 99) < 80)
			return addr_mask ^ ADDR_W'($urandom_range(0, 3));
		return ADDR_W'($urandom_range(0, 127));
	endfunction

	function automatic logic [INST_W-1:0] pick_instance();
		if ($urandom_range(0, 99) < 80)
			return inst_mask ^ INST_W'($urandom_range(0, 2));
		return INST_W'($urandom_range(0, 15));
	endfunction

	always @(posedge clk) begin : sender
		table_cmd_t c;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(apply_table_op(in_flight));
				items_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_cmds.size() == 0 ||
						(pending_cmds[0].drain_first && expected_results.size() != 0)) begin
					s_axis_tvalid <= 1'b0;
				end else begin
					c = pending_cmds.pop_front();
					in_flight = c;
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {{(S_TDATA_W-ADDR_W-INST_W){1'b0}},
						c.iface_instance, c.dev_address};
					s_axis_tuser <= {c.match_any_instance, c.opcode};
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	always @(posedge clk) begin : receiver
		if (arst_n) begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			if (!long_hold_done && items_accepted >= 500) begin
				long_hold_done = 1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_FREE:   m_axis_tready <= 1'b1;
					RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default:   m_axis_tready <= !m_axis_tready;
				endcase
			end
		end
	end

	always @(posedge clk) begin : monitor
		table_result_t got;
		table_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tuser[STATUS_W-1:0];
			got.slot_index = m_axis_tdata[INDEX_W-1:0];
			got.removed_count = m_axis_tdata[INDEX_W +: COUNT_W];
			got.entry_count = m_axis_tdata[INDEX_W+COUNT_W +: COUNT_W];
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, status", got.status, 0);
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status)
					report_mismatch("status", got.status, want.status);
				if (got.slot_index !== want.slot_index)
					report_mismatch("slot_index", got.slot_index, want.slot_index);
				if (got.removed_count !== want.removed_count)
					report_mismatch("removed_count", got.removed_count, want.removed_count);
				if (got.entry_count !== want.entry_count)
					report_mismatch("entry_count", got.entry_count, want.entry_count);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		int p;
		int k;
		int pick;
		int add_pct;
		int remove_pct;
		logic [OPCODE_W-1:0] op;

		push_cmd(OP_FIND, 7'd0, 4'd0, 1'b0, 0);
		push_cmd(OP_REMOVE, 7'd0, 4'd0, 1'b1, 0);
		push_cmd(OP_ADD, 7'd127, 4'd15, 1'b0, 0);
		push_cmd(OP_ADD, 7'd0, 4'd0, 1'b1, 0);
		push_cmd(OP_ADD, 7'd127, 4'd15, 1'b0, 0);
		push_cmd(OP_ADD, 7'd127, 4'd0, 1'b0, 0);
		push_cmd(OP_FIND, 7'd127, 4'd15, 1'b1, 0);
		push_cmd(OP_FIND, 7'd0, 4'd0, 1'b0, 0);
		push_cmd(OP_UNUSED, 7'd85, 4'd10, 1'b0, 0);
		push_cmd(OP_REMOVE, 7'd127, 4'd15, 1'b0, 0);
		push_cmd(OP_ADD, 7'd5, 4'd3, 1'b0, 0);
		push_cmd(OP_ADD, 7'd5, 4'd4, 1'b0, 0);
		push_cmd(OP_ADD, 7'd5, 4'd5, 1'b0, 0);
		push_cmd(OP_ADD, 7'd6, 4'd1, 1'b0, 0);
		push_cmd(OP_ADD, 7'd42, 4'd9, 1'b0, 0);
		push_cmd(OP_ADD, 7'd127, 4'd15, 1'b0, 0);
		push_cmd(OP_ADD, 7'd1, 4'd1, 1'b0, 0);
		push_cmd(OP_FIND, 7'd42, 4'd9, 1'b0, 0);
		push_cmd(OP_FIND, 7'd9, 4'd9, 1'b0, 0);
		push_cmd(OP_REMOVE, 7'd5, 4'd0, 1'b1, 0);
		push_cmd(OP_REMOVE, 7'd0, 4'd0, 1'b0, 0);
		push_cmd(OP_FIND, 7'd127, 4'd15, 1'b0, 0);
		push_cmd(OP_UNUSED, 7'd42, 4'd5, 1'b1, 0);
		push_cmd(OP_REMOVE, 7'd127, 4'd7, 1'b1, 0);

		// alternate grow and shrink phases; each phase waits for a drained block
		for (p = 0; p < PHASES; p++) begin
			addr_mask = ADDR_W'($urandom_range(0, 127));
			inst_mask = INST_W'($urandom_range(0, 15));
			add_pct = (p % 2 == 0) ? 55 : 20;
			remove_pct = (p % 2 == 0) ? 15 : 45;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < add_pct)
					op = OP_ADD;
				else if (pick < add_pct + remove_pct)
					op = OP_REMOVE;
				else if (pick < 99)
					op = OP_FIND;
				else
					op = OP_UNUSED;
				push_cmd(op, pick_address(), pick_instance(),
					($urandom_range(0, 99) < 30), (k == 0));
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
